### hw/rtl/arm_banked_registers_exceptions_top_assert.svh
// Assertion macros shared by the register file RTL.
// Each macro samples on i_clk and is quiet while i_rst_n is low.
`ifndef ARM_BANKED_REGISTERS_EXCEPTIONS_TOP_ASSERT_SVH
`define ARM_BANKED_REGISTERS_EXCEPTIONS_TOP_ASSERT_SVH

// Same-cycle implication
`define ABRE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ABRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/abre_pkg.sv
// ---------------------------------------------------------------------------
// abre_pkg
// Types, codes and vector tables for the banked ARM register file.
// ---------------------------------------------------------------------------
package abre_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_bank;
    typedef logic [4:0]  t_mode;

    // Commands
    typedef enum logic [3:0] {
        CMD_READREG     = 4'd0,
        CMD_WRITEREG    = 4'd1,
        CMD_WRITECPSR   = 4'd2,
        CMD_RESTORECPSR = 4'd3,
        CMD_WRITESPSR   = 4'd4,
        CMD_EXCEPTION   = 4'd5,
        CMD_JUMP        = 4'd6,
        CMD_CHECKIRQ    = 4'd7,
        CMD_HALT        = 4'd8
    } t_cmd;

    // Exception kinds
    typedef enum logic [2:0] {
        EXC_RESET  = 3'd0,
        EXC_UNDEF  = 3'd1,
        EXC_SWI    = 3'd2,
        EXC_PABORT = 3'd3,
        EXC_DABORT = 3'd4,
        EXC_IRQ    = 3'd5,
        EXC_FIQ    = 3'd6,
        EXC_NONE   = 3'd7
    } t_exc;

    // Mode codes
    localparam t_mode MODE_FIQ = 5'h11;
    localparam t_mode MODE_IRQ = 5'h12;
    localparam t_mode MODE_SVC = 5'h13;
    localparam t_mode MODE_ABT = 5'h17;
    localparam t_mode MODE_UND = 5'h1B;

    // Bank numbers
    localparam t_bank BANK_USR = 3'd0;
    localparam t_bank BANK_FIQ = 3'd1;
    localparam t_bank BANK_IRQ = 3'd2;
    localparam t_bank BANK_SVC = 3'd3;
    localparam t_bank BANK_ABT = 3'd4;
    localparam t_bank BANK_UND = 3'd5;
    localparam int    NUM_BANKS = 6;

    // CPSR bits and constants
    localparam int    BIT_THUMB = 5;
    localparam int    BIT_FIQ   = 6;
    localparam int    BIT_IRQ   = 7;
    localparam t_word HIGH_BASE = 32'hFFFF0000;
    localparam t_word CPSR_RESET = 32'h000000D3;
    localparam t_word PC_RESET   = 32'h00000008;

    // Register indexes
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    // Configuration register addresses (word index)
    localparam logic CFG_ARM9    = 1'b0;
    localparam logic CFG_HIGHVEC = 1'b1;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] value;
        logic        interwork;
        logic [2:0]  exception_kind;
        logic        irq_line;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] status_word;
        logic [31:0] saved_status;
        logic [31:0] program_counter;
        logic        took_jump;
        logic        is_halted;
    } t_out_item;

    typedef struct packed {
        logic core_is_arm9;
        logic high_vectors;
    } t_cfg;

    function automatic t_bank bank_for(input t_mode mode);
        case (mode)
            MODE_FIQ: bank_for = BANK_FIQ;
            MODE_IRQ: bank_for = BANK_IRQ;
            MODE_SVC: bank_for = BANK_SVC;
            MODE_ABT: bank_for = BANK_ABT;
            MODE_UND: bank_for = BANK_UND;
            default:  bank_for = BANK_USR;
        endcase
    endfunction

    function automatic t_word vec_off(input logic [2:0] kind);
        case (t_exc'(kind))
            EXC_RESET:  vec_off = 32'h00;
            EXC_UNDEF:  vec_off = 32'h04;
            EXC_SWI:    vec_off = 32'h08;
            EXC_PABORT: vec_off = 32'h0C;
            EXC_DABORT: vec_off = 32'h10;
            EXC_IRQ:    vec_off = 32'h18;
            EXC_FIQ:    vec_off = 32'h1C;
            default:    vec_off = 32'h00;
        endcase
    endfunction

    function automatic t_mode vec_mode(input logic [2:0] kind);
        case (t_exc'(kind))
            EXC_UNDEF:  vec_mode = MODE_UND;
            EXC_PABORT: vec_mode = MODE_ABT;
            EXC_DABORT: vec_mode = MODE_ABT;
            EXC_IRQ:    vec_mode = MODE_IRQ;
            EXC_FIQ:    vec_mode = MODE_FIQ;
            default:    vec_mode = MODE_SVC;
        endcase
    endfunction

    // Return address adjustment, by kind and by the old Thumb state
    function automatic t_word lr_adjust(input logic [2:0] kind, input logic thumb);
        case (t_exc'(kind))
            EXC_UNDEF:  lr_adjust = thumb ? 32'd2 : 32'd4;
            EXC_SWI:    lr_adjust = thumb ? 32'd2 : 32'd4;
            EXC_PABORT: lr_adjust = thumb ? 32'd0 : 32'd4;
            EXC_DABORT: lr_adjust = thumb ? 32'hFFFFFFFC : 32'd0;
            EXC_IRQ:    lr_adjust = thumb ? 32'd0 : 32'd4;
            EXC_FIQ:    lr_adjust = thumb ? 32'd0 : 32'd4;
            default:    lr_adjust = 32'd0;
        endcase
    endfunction

endpackage

### hw/rtl/abre_core.sv
// ---------------------------------------------------------------------------
// abre_core
// Architectural state and single-pass command execution with bank swaps.
// ---------------------------------------------------------------------------
module abre_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  abre_pkg::t_in_item   i_item,
    input  abre_pkg::t_cfg       i_cfg,
    output abre_pkg::t_out_item  o_result
);

    abre_pkg::t_word r_regs  [16];
    abre_pkg::t_word n_regs  [16];
    abre_pkg::t_word r_sp    [abre_pkg::NUM_BANKS];
    abre_pkg::t_word n_sp    [abre_pkg::NUM_BANKS];
    abre_pkg::t_word r_lr    [abre_pkg::NUM_BANKS];
    abre_pkg::t_word n_lr    [abre_pkg::NUM_BANKS];
    abre_pkg::t_word r_bspsr [abre_pkg::NUM_BANKS];
    abre_pkg::t_word n_bspsr [abre_pkg::NUM_BANKS];
    abre_pkg::t_word r_hi    [10];
    abre_pkg::t_word n_hi    [10];
    abre_pkg::t_word r_cpsr, n_cpsr;
    abre_pkg::t_word r_spsr, n_spsr;
    logic            r_halt, n_halt;

    logic            chg_en;
    logic            exc_en;
    logic [2:0]      exc_kind;
    logic            took_jump;
    logic            thumb;
    abre_pkg::t_mode tgt_mode;
    abre_pkg::t_bank ob, nb;
    abre_pkg::t_word vbase;

    // Decode which commands change mode or enter an exception
    always_comb begin
        chg_en   = 1'b0;
        exc_en   = 1'b0;
        exc_kind = i_item.exception_kind;
        tgt_mode = r_cpsr[4:0];
        case (abre_pkg::t_cmd'(i_item.command))
            abre_pkg::CMD_WRITECPSR: begin
                chg_en   = 1'b1;
                tgt_mode = i_item.value[4:0];
            end
            abre_pkg::CMD_RESTORECPSR: begin
                chg_en   = 1'b1;
                tgt_mode = r_spsr[4:0];
            end
            abre_pkg::CMD_EXCEPTION: begin
                exc_en = (i_item.exception_kind != abre_pkg::EXC_NONE);
            end
            abre_pkg::CMD_CHECKIRQ: begin
                exc_en   = i_item.irq_line && !r_cpsr[abre_pkg::BIT_IRQ];
                exc_kind = abre_pkg::EXC_IRQ;
            end
            default: begin
            end
        endcase
        if (exc_en) begin
            chg_en   = 1'b1;
            tgt_mode = abre_pkg::vec_mode(exc_kind);
        end
    end

    assign ob    = abre_pkg::bank_for(r_cpsr[4:0]);
    assign nb    = abre_pkg::bank_for(tgt_mode);
    assign vbase = (i_cfg.core_is_arm9 && i_cfg.high_vectors) ? abre_pkg::HIGH_BASE : '0;
    assign thumb = i_item.interwork ? i_item.value[0] : r_cpsr[abre_pkg::BIT_THUMB];

    // Next state: bank swap first, then the command itself
    always_comb begin
        n_regs  = r_regs;
        n_sp    = r_sp;
        n_lr    = r_lr;
        n_bspsr = r_bspsr;
        n_hi    = r_hi;
        n_cpsr  = r_cpsr;
        n_spsr  = r_spsr;
        n_halt  = r_halt;
        took_jump = 1'b0;

        if (chg_en && (ob != nb)) begin
            n_sp[ob] = r_regs[abre_pkg::REG_SP];
            n_lr[ob] = r_regs[abre_pkg::REG_LR];
            if (ob != abre_pkg::BANK_USR) begin
                n_bspsr[ob] = r_spsr;
            end
            n_regs[abre_pkg::REG_SP] = r_sp[nb];
            n_regs[abre_pkg::REG_LR] = r_lr[nb];
            n_spsr = (nb != abre_pkg::BANK_USR) ? r_bspsr[nb] : '0;
            for (int i = 0; i < 5; i++) begin
                if (ob == abre_pkg::BANK_FIQ) begin
                    n_hi[5 + i]   = r_regs[8 + i];
                    n_regs[8 + i] = r_hi[i];
                end else if (nb == abre_pkg::BANK_FIQ) begin
                    n_hi[i]       = r_regs[8 + i];
                    n_regs[8 + i] = r_hi[5 + i];
                end
            end
        end
        if (chg_en) begin
            n_cpsr[4:0] = tgt_mode;
        end

        case (abre_pkg::t_cmd'(i_item.command))
            abre_pkg::CMD_WRITEREG:    n_regs[i_item.reg_index] = i_item.value;
            abre_pkg::CMD_WRITECPSR:   n_cpsr = i_item.value;
            abre_pkg::CMD_RESTORECPSR: n_cpsr = r_spsr;
            abre_pkg::CMD_WRITESPSR:   n_spsr = i_item.value;
            abre_pkg::CMD_JUMP: begin
                took_jump = 1'b1;
                n_cpsr[abre_pkg::BIT_THUMB] = thumb;
                n_regs[abre_pkg::REG_PC] = thumb ?
                    ({i_item.value[31:1], 1'b0} + 32'd4) :
                    ({i_item.value[31:2], 2'b00} + 32'd8);
            end
            abre_pkg::CMD_CHECKIRQ: begin
                if (exc_en) begin
                    n_halt = 1'b0;
                end
            end
            abre_pkg::CMD_HALT:        n_halt = 1'b1;
            default: begin
            end
        endcase

        // Exception entry (also the IRQ taken by checkirq)
        if (exc_en) begin
            took_jump = 1'b1;
            n_spsr = r_cpsr;
            n_regs[abre_pkg::REG_LR] = r_regs[abre_pkg::REG_PC] -
                abre_pkg::lr_adjust(exc_kind, r_cpsr[abre_pkg::BIT_THUMB]);
            n_cpsr[abre_pkg::BIT_THUMB] = 1'b0;
            n_cpsr[abre_pkg::BIT_IRQ]   = 1'b1;
            if (exc_kind == abre_pkg::EXC_RESET || exc_kind == abre_pkg::EXC_IRQ ||
                exc_kind == abre_pkg::EXC_FIQ) begin
                n_cpsr[abre_pkg::BIT_FIQ] = 1'b1;
            end
            n_regs[abre_pkg::REG_PC] = vbase + abre_pkg::vec_off(exc_kind) + 32'd8;
        end
    end

    // Result reflects the state after this command
    always_comb begin
        o_result.read_data       = n_regs[i_item.reg_index];
        o_result.status_word     = n_cpsr;
        o_result.saved_status    = n_spsr;
        o_result.program_counter = n_regs[abre_pkg::REG_PC];
        o_result.took_jump       = took_jump;
        o_result.is_halted       = n_halt;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_regs[i] <= (4'(i) == abre_pkg::REG_PC) ? abre_pkg::PC_RESET : '0;
            end
            for (int i = 0; i < abre_pkg::NUM_BANKS; i++) begin
                r_sp[i]    <= '0;
                r_lr[i]    <= '0;
                r_bspsr[i] <= '0;
            end
            for (int i = 0; i < 10; i++) begin
                r_hi[i] <= '0;
            end
            r_cpsr <= abre_pkg::CPSR_RESET;
            r_spsr <= '0;
            r_halt <= 1'b0;
        end else if (i_fire) begin
            r_regs  <= n_regs;
            r_sp    <= n_sp;
            r_lr    <= n_lr;
            r_bspsr <= n_bspsr;
            r_hi    <= n_hi;
            r_cpsr  <= n_cpsr;
            r_spsr  <= n_spsr;
            r_halt  <= n_halt;
        end
    end

endmodule

### hw/rtl/arm_banked_registers_exceptions_top.sv
// ---------------------------------------------------------------------------
// arm_banked_registers_exceptions_top
// ARM register file with mode banking, SPSR handling and exception entry.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//   out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//   cfg     | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// One command per cycle sustained while i_out_stall is low; an accepted beat
// waits in the input register, then its result fills the result register.
// All banked state is in flops, so a mode change swaps banks in that pass.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// A stalled result holds the execute stage; the input register still takes
// one more beat while it is empty.
// ---------------------------------------------------------------------------
`include "arm_banked_registers_exceptions_top_assert.svh"

module arm_banked_registers_exceptions_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  abre_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output abre_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic                r_in_valid;
    abre_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    abre_pkg::t_out_item r_out_data;
    abre_pkg::t_cfg      r_cfg;
    abre_pkg::t_out_item result;
    logic                out_ready;
    logic                fire;
    logic                accept;

    // Pipeline control
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
    end

    // Execute stage
    abre_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.core_is_arm9 <= 1'b1;
            r_cfg.high_vectors <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                abre_pkg::CFG_ARM9:    r_cfg.core_is_arm9 <= pwdata[0];
                abre_pkg::CFG_HIGHVEC: r_cfg.high_vectors <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            abre_pkg::CFG_ARM9:    prdata = {31'd0, r_cfg.core_is_arm9};
            abre_pkg::CFG_HIGHVEC: prdata = {31'd0, r_cfg.high_vectors};
            default:               prdata = '0;
        endcase
    end

    // Checks
    `ABRE_ASSERT_NEXT(a_fire_fills_out, fire, r_out_valid)
    `ABRE_ASSERT_IMPLY(a_stall_needs_item, o_in_stall, r_in_valid && r_out_valid)
    `ABRE_ASSERT_NEXT(a_stall_keeps_item, o_in_stall, r_in_valid)
    `ABRE_ASSERT_NEXT(a_exc_masks_irq, fire && (r_in_data.command == abre_pkg::CMD_EXCEPTION) && (r_in_data.exception_kind != abre_pkg::EXC_NONE), o_out_data.status_word[abre_pkg::BIT_IRQ] && o_out_data.took_jump)

endmodule
